// ===== src/ppr_pkg.sv =====
// Package for the pipe pool ring FIFO unit.
// Holds sizes, operation and status codes, controller states and the
// command/status structs shared by the controller, datapath and top level.
`default_nettype none

package ppr_pkg;

  // Pool geometry; ring depth is a power of two
  localparam int unsigned PIPE_SLOTS = 8;
  localparam int unsigned PIPE_DEPTH = 512;
  localparam int unsigned SLOT_W     = $clog2(PIPE_SLOTS);
  localparam int unsigned OFFS_W     = $clog2(PIPE_DEPTH);
  localparam int unsigned PTR_W      = OFFS_W + 1;
  localparam int unsigned ADDR_W     = SLOT_W + OFFS_W;
  localparam int unsigned MEM_WORDS  = PIPE_SLOTS * PIPE_DEPTH;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned STAT_W     = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC       = 3'd0,
    MODE_OPEN_READ   = 3'd1,
    MODE_OPEN_WRITE  = 3'd2,
    MODE_CLOSE_READ  = 3'd3,
    MODE_CLOSE_WRITE = 3'd4,
    MODE_READ        = 3'd5,
    MODE_WRITE       = 3'd6
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_EOF    = 3'd2,
    ST_FULL   = 3'd3,
    ST_BROKEN = 3'd4,
    ST_NOSLOT = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    CS_IDLE   = 1'b0,
    CS_RDWAIT = 1'b1
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // request taken this cycle
    logic load_result; // load result register from the request itself
    logic load_read;   // load result register from memory read data
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rd_hit;      // current request is a read of a nonempty ring
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/ppr_ctrl.sv =====
// Controller for the pipe pool ring FIFO unit.
// Sequences one request at a time and owns the input and output handshakes.
// Depends on ppr_pkg.
`default_nettype none

module ppr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire ppr_pkg::dp_sts_t sts_i,
  output ppr_pkg::dp_cmd_t     cmd_o
);
  import ppr_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;
  logic        accept;

  // Result register is free, or is emptied at this edge
  assign slot_free = !out_valid_q || !out_stall_i;
  assign accept    = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (accept && sts_i.rd_hit) state_d = CS_RDWAIT;
      end
      CS_RDWAIT: begin
        state_d = CS_IDLE;
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o        = 1'b1;
    cmd_o.accept      = 1'b0;
    cmd_o.load_result = 1'b0;
    cmd_o.load_read   = 1'b0;
    case (state_q)
      CS_IDLE: begin
        in_stall_o        = !slot_free;
        cmd_o.accept      = in_valid_i && slot_free;
        cmd_o.load_result = in_valid_i && slot_free && !sts_i.rd_hit;
      end
      CS_RDWAIT: begin
        cmd_o.load_read = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Set on a result load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_result || cmd_o.load_read) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/ppr_dpath.sv =====
// Datapath for the pipe pool ring FIFO unit: ring memory, per-slot pointers
// and end counts, allocation search and the result register.
// Depends on ppr_pkg.
`default_nettype none

module ppr_dpath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ppr_pkg::dp_cmd_t               cmd_i,
  output ppr_pkg::dp_sts_t                    sts_o,
  input  wire logic [ppr_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [ppr_pkg::SLOT_W-1:0]     pipe_index_i,
  input  wire logic [ppr_pkg::BYTE_W-1:0]     write_byte_i,
  output logic      [ppr_pkg::STAT_W-1:0]     status_o,
  output logic      [ppr_pkg::BYTE_W-1:0]     read_byte_o,
  output logic      [ppr_pkg::SLOT_W-1:0]     pipe_number_o
);
  import ppr_pkg::*;

  logic [BYTE_W-1:0] mem [MEM_WORDS];
  logic [BYTE_W-1:0] mem_rdata_q;

  logic [PTR_W-1:0]  wptr_q [PIPE_SLOTS];
  logic [PTR_W-1:0]  rptr_q [PIPE_SLOTS];
  logic [CNT_W-1:0]  rcnt_q [PIPE_SLOTS];
  logic [CNT_W-1:0]  wcnt_q [PIPE_SLOTS];

  logic [STAT_W-1:0] status_q;
  logic [BYTE_W-1:0] rbyte_q;
  logic [SLOT_W-1:0] number_q;

  mode_e             mode;
  logic [PTR_W-1:0]  cur_wptr, cur_rptr, fill;
  logic [CNT_W-1:0]  cur_rcnt, cur_wcnt;
  logic              is_empty, is_full;
  logic              wr_ok;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  status_e           status_n;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign mode     = mode_e'(mode_i);
  assign cur_wptr = wptr_q[pipe_index_i];
  assign cur_rptr = rptr_q[pipe_index_i];
  assign cur_rcnt = rcnt_q[pipe_index_i];
  assign cur_wcnt = wcnt_q[pipe_index_i];
  assign fill     = cur_wptr - cur_rptr;
  assign is_empty = (cur_wptr == cur_rptr);
  assign is_full  = fill[PTR_W-1];
  assign wr_ok    = (mode == MODE_WRITE) && (cur_rcnt != '0) && !is_full;

  assign sts_o.rd_hit = (mode == MODE_READ) && !is_empty;

  assign wr_addr = {pipe_index_i, cur_wptr[OFFS_W-1:0]};
  assign rd_addr = {pipe_index_i, cur_rptr[OFFS_W-1:0]};

  // Find the lowest slot with no readers and no writers
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = PIPE_SLOTS - 1; i >= 0; i--) begin
      if (rcnt_q[i] == '0 && wcnt_q[i] == '0) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  // Status of a request that completes at once
  always_comb begin
    status_n = ST_OK;
    case (mode)
      MODE_ALLOC: begin
        status_n = free_found ? ST_OK : ST_NOSLOT;
      end
      MODE_READ: begin
        if (is_empty) status_n = (cur_wcnt == '0) ? ST_EOF : ST_EMPTY;
      end
      MODE_WRITE: begin
        if (cur_rcnt == '0)  status_n = ST_BROKEN;
        else if (is_full)    status_n = ST_FULL;
      end
      default: begin
        status_n = ST_OK;
      end
    endcase
  end

  // Ring memory: one write or one registered read per request
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_ok) begin
      mem[wr_addr] <= write_byte_i;
    end
    if (cmd_i.accept && sts_o.rd_hit) begin
      mem_rdata_q <= mem[rd_addr];
    end
  end

  // Pointers and end counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_SLOTS; i++) begin
        wptr_q[i] <= '0;
        rptr_q[i] <= '0;
        rcnt_q[i] <= '0;
        wcnt_q[i] <= '0;
      end
    end else if (cmd_i.accept) begin
      case (mode)
        MODE_ALLOC: begin
          if (free_found) begin
            wptr_q[free_slot] <= '0;
            rptr_q[free_slot] <= '0;
            rcnt_q[free_slot] <= CNT_W'(1);
            wcnt_q[free_slot] <= CNT_W'(1);
          end
        end
        MODE_OPEN_READ: begin
          if (cur_rcnt != CNT_MAX) rcnt_q[pipe_index_i] <= cur_rcnt + 1'b1;
        end
        MODE_OPEN_WRITE: begin
          if (cur_wcnt != CNT_MAX) wcnt_q[pipe_index_i] <= cur_wcnt + 1'b1;
        end
        MODE_CLOSE_READ: begin
          if (cur_rcnt != '0) rcnt_q[pipe_index_i] <= cur_rcnt - 1'b1;
        end
        MODE_CLOSE_WRITE: begin
          if (cur_wcnt != '0) wcnt_q[pipe_index_i] <= cur_wcnt - 1'b1;
        end
        MODE_READ: begin
          if (sts_o.rd_hit) rptr_q[pipe_index_i] <= cur_rptr + 1'b1;
        end
        MODE_WRITE: begin
          if (wr_ok) wptr_q[pipe_index_i] <= cur_wptr + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_read) begin
      status_q <= ST_OK;
      rbyte_q  <= mem_rdata_q;
      number_q <= '0;
    end else if (cmd_i.load_result) begin
      status_q <= status_n;
      rbyte_q  <= '0;
      number_q <= (mode == MODE_ALLOC && free_found) ? free_slot : '0;
    end
  end

  assign status_o      = status_q;
  assign read_byte_o   = rbyte_q;
  assign pipe_number_o = number_q;

endmodule

`default_nettype wire

// ===== src/pipe_pool_ring_fifo_unit.sv =====
// Top level of the pipe pool ring FIFO unit: controller plus datapath.
// Depends on ppr_pkg, ppr_ctrl and ppr_dpath.
//
//  Channel  Handshake             Payload
//  -------  --------------------  ------------------------------------------
//  in       in_valid_i/in_stall_o mode_i, pipe_index_i, write_byte_i
//  out      out_valid_o/out_stall_i status_o, read_byte_o, pipe_number_o
//
// Every request gives one result. A read that returns a byte first passes
// through a registered read of the ring memory, stalling the input meanwhile.
// A new request is taken while the result register is empty or being taken.
// Reset clears all pointers and end counts at once; no clearing pass.
// A stalled result holds the result register and stalls the input.
`default_nettype none

module pipe_pool_ring_fifo_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [ppr_pkg::MODE_W-1:0]  mode_i,
  input  wire logic [ppr_pkg::SLOT_W-1:0]  pipe_index_i,
  input  wire logic [ppr_pkg::BYTE_W-1:0]  write_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [ppr_pkg::STAT_W-1:0]  status_o,
  output logic      [ppr_pkg::BYTE_W-1:0]  read_byte_o,
  output logic      [ppr_pkg::SLOT_W-1:0]  pipe_number_o
);
  import ppr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ppr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppr_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (mode_i),
    .pipe_index_i  (pipe_index_i),
    .write_byte_i  (write_byte_i),
    .status_o      (status_o),
    .read_byte_o   (read_byte_o),
    .pipe_number_o (pipe_number_o)
  );

  // A read that hits leaves the result register empty while memory answers
  a_rd_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && sts.rd_hit) |=> (!out_valid_o && in_stall_o))
    else $error("read hit did not wait for memory data");

  // Any other request shows its result in the next cycle
  a_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !sts.rd_hit) |=> out_valid_o)
    else $error("result missing after single-cycle request");

  // Only a successful read carries a byte
  a_byte_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (read_byte_o == '0))
    else $error("failed request carries a read byte");

  // A failed allocate reports slot zero
  a_noslot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_NOSLOT) |-> (pipe_number_o == '0))
    else $error("failed allocate reports a slot");

endmodule

`default_nettype wire
